// File: hw/rtl/wftc_pkg.sv
// Shared types and constants for the wildcard five-tuple classifier.
// Used by the top level, wftc_front and wftc_back; depends on nothing else.
`default_nettype none

package wftc_pkg;

   // Widths of one rule entry as it is kept in the three rule memories.
   localparam int unsigned ADDR_PAIR_W = 64;
   localparam int unsigned PORT_PAIR_W = 32;
   localparam int unsigned META_W      = 33;

   // Request kinds.
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_WRITE  = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_MATCH   = 2'd0;
   localparam logic [1:0] STATUS_NOMATCH = 2'd1;
   localparam logic [1:0] STATUS_WRITTEN = 2'd2;

   // One accepted request word as it waits in the queue.
   typedef struct packed {
      logic        req_type;
      logic        direction;
      logic [5:0]  entry_index;
      logic        entry_valid;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  protocol;
      logic [7:0]  rule_type;
      logic [7:0]  rule_action;
      logic [7:0]  rule_alg;
   } req_item_type;

   // Head of the request queue as seen by the execution side.
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } queue_head_type;

   // Layout of the rule metadata word.
   typedef struct packed {
      logic       entry_valid;
      logic [7:0] rule_type;
      logic [7:0] rule_action;
      logic [7:0] rule_alg;
      logic [7:0] protocol;
   } rule_meta_type;

endpackage

`default_nettype wire

// File: hw/rtl/wildcard_five_tuple_classifier.sv
// Top level of the wildcard five-tuple classifier.
// Depends on wftc_pkg, wftc_front, wftc_back (and wftc_ram through wftc_back).
//
//   Channel  Direction  Handshake             Carries
//   req_     in         req_valid/req_stall   rule write word or lookup tuple word
//   rsp_     out        rsp_valid/rsp_stall   status, policy type, action, algorithm
//
// A write word is answered without a scan: its result word is loaded as it leaves the queue.
// A lookup word is answered by a scan that reads one rule per cycle from the
// rule memories' single read port; it ends early at the first matching rule.
// After reset a clearing pass writes the metadata of all 2 * RULES_PER_DIRECTION
// rule slots and marks every rule invalid; req_stall stays high during it.
// The request queue holds two words, so the requester keeps going while a
// result word waits under rsp_stall, until the queue is full.
`default_nettype none

module wildcard_five_tuple_classifier #(
   parameter int unsigned RULES_PER_DIRECTION = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic        req_direction,
   input  wire logic [5:0]  req_entry_index,
   input  wire logic        req_entry_valid,
   input  wire logic [31:0] req_src_addr,
   input  wire logic [31:0] req_dst_addr,
   input  wire logic [15:0] req_src_port,
   input  wire logic [15:0] req_dst_port,
   input  wire logic [7:0]  req_protocol,
   input  wire logic [7:0]  req_rule_type,
   input  wire logic [7:0]  req_rule_action,
   input  wire logic [7:0]  req_rule_alg,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_policy_type,
   output logic [7:0]       rsp_policy_action,
   output logic [7:0]       rsp_policy_alg
);

   wftc_pkg::req_item_type   req_item;
   wftc_pkg::queue_head_type head;
   logic                     pop;
   logic                     clearing;

   // Gather the request fields into one queue word.
   assign req_item.req_type    = req_type;
   assign req_item.direction   = req_direction;
   assign req_item.entry_index = req_entry_index;
   assign req_item.entry_valid = req_entry_valid;
   assign req_item.src_addr    = req_src_addr;
   assign req_item.dst_addr    = req_dst_addr;
   assign req_item.src_port    = req_src_port;
   assign req_item.dst_port    = req_dst_port;
   assign req_item.protocol    = req_protocol;
   assign req_item.rule_type   = req_rule_type;
   assign req_item.rule_action = req_rule_action;
   assign req_item.rule_alg    = req_rule_alg;

   // The front end accepts words and queues them.
   wftc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .pop       (pop),
      .head      (head)
   );

   // The back end owns the rule memories, executes writes, runs the
   // first-match scan and holds the result word until it is taken.
   wftc_back #(.RULES_PER_DIRECTION(RULES_PER_DIRECTION)) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_policy_type   (rsp_policy_type),
      .rsp_policy_action (rsp_policy_action),
      .rsp_policy_alg    (rsp_policy_alg)
   );

endmodule

`default_nettype wire

// File: hw/rtl/wftc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Stands alone; used for every rule memory of the classifier.
`default_nettype none

module wftc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/wftc_front.sv
// Front end of the classifier: accepts request words into a two-entry queue.
// Depends on wftc_pkg for the request word type.
`default_nettype none

module wftc_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    clearing,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire wftc_pkg::req_item_type  req_item,
   input  wire logic                    pop,
   output wftc_pkg::queue_head_type     head
);

   wftc_pkg::req_item_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // The queue takes nothing while the rule memories are being cleared.
   assign req_stall = clearing || (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_item;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: hw/rtl/wftc_back.sv
// Back end of the classifier: clears the rule metadata memory, executes rule writes
// and scans one direction's rules per lookup. Depends on wftc_pkg and wftc_ram.
`default_nettype none

module wftc_back #(
   parameter int unsigned RULES_PER_DIRECTION = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire wftc_pkg::queue_head_type  head,
   output logic                           pop,
   output logic                           clearing,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [7:0]                     rsp_policy_type,
   output logic [7:0]                     rsp_policy_action,
   output logic [7:0]                     rsp_policy_alg
);

   localparam int unsigned DEPTH = 2 * RULES_PER_DIRECTION;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(RULES_PER_DIRECTION + 1);

   localparam logic [1:0] SB_CLEAR = 2'd0;
   localparam logic [1:0] SB_IDLE  = 2'd1;
   localparam logic [1:0] SB_SCAN  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [CW-1:0]          scan_ff, scan_in;
   logic                   rd_pend_ff, rd_pend_in;
   wftc_pkg::req_item_type cur_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_load;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [7:0]             rsp_type_ff, rsp_type_in;
   logic [7:0]             rsp_action_ff, rsp_action_in;
   logic [7:0]             rsp_alg_ff, rsp_alg_in;

   logic                   out_free;
   logic                   idx_ok;
   logic                   rule_we;
   logic                   meta_we;
   logic [AW-1:0]          head_base;
   logic [AW-1:0]          cur_base;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   wftc_pkg::rule_meta_type meta_wdata;
   logic [wftc_pkg::ADDR_PAIR_W-1:0] addr_rdata;
   logic [wftc_pkg::PORT_PAIR_W-1:0] port_rdata;
   logic [wftc_pkg::META_W-1:0]      meta_rdata;
   wftc_pkg::rule_meta_type rd_meta;
   logic                   hit;
   logic                   scan_end;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == SB_IDLE) && head.valid && out_free;
   assign clearing = (state_ff == SB_CLEAR);

   // Slot placement: direction 0 rules first, direction 1 rules after them.
   assign head_base = head.item.direction ? AW'(RULES_PER_DIRECTION) : '0;
   assign cur_base  = cur_ff.direction ? AW'(RULES_PER_DIRECTION) : '0;
   assign idx_ok    = ({26'd0, head.item.entry_index} < 32'(RULES_PER_DIRECTION));

   assign rule_we = pop && (head.item.req_type == wftc_pkg::REQ_WRITE) && idx_ok;
   assign meta_we = clearing || rule_we;
   assign wr_addr = clearing ? clr_ff : (head_base + AW'(head.item.entry_index));
   assign rd_addr = cur_base + AW'(scan_ff);

   always_comb begin
      if (clearing) begin
         meta_wdata = '0;
      end else begin
         meta_wdata.entry_valid = head.item.entry_valid;
         meta_wdata.rule_type   = head.item.rule_type;
         meta_wdata.rule_action = head.item.rule_action;
         meta_wdata.rule_alg    = head.item.rule_alg;
         meta_wdata.protocol    = head.item.protocol;
      end
   end

   wftc_ram #(.WIDTH(wftc_pkg::ADDR_PAIR_W), .DEPTH(DEPTH)) u_addr_ram (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (wr_addr),
      .wr_data ({head.item.src_addr, head.item.dst_addr}),
      .rd_addr (rd_addr),
      .rd_data (addr_rdata)
   );

   wftc_ram #(.WIDTH(wftc_pkg::PORT_PAIR_W), .DEPTH(DEPTH)) u_port_ram (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (wr_addr),
      .wr_data ({head.item.src_port, head.item.dst_port}),
      .rd_addr (rd_addr),
      .rd_data (port_rdata)
   );

   wftc_ram #(.WIDTH(wftc_pkg::META_W), .DEPTH(DEPTH)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (wr_addr),
      .wr_data (meta_wdata),
      .rd_addr (rd_addr),
      .rd_data (meta_rdata)
   );

   // A rule field of zero matches anything.
   assign rd_meta = meta_rdata;
   assign hit = rd_pend_ff && rd_meta.entry_valid
      && ((addr_rdata[63:32] == 32'd0) || (addr_rdata[63:32] == cur_ff.src_addr))
      && ((addr_rdata[31:0] == 32'd0) || (addr_rdata[31:0] == cur_ff.dst_addr))
      && ((port_rdata[31:16] == 16'd0) || (port_rdata[31:16] == cur_ff.src_port))
      && ((port_rdata[15:0] == 16'd0) || (port_rdata[15:0] == cur_ff.dst_port))
      && ((rd_meta.protocol == 8'd0) || (rd_meta.protocol == cur_ff.protocol));
   assign scan_end = (scan_ff == CW'(RULES_PER_DIRECTION));

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      rd_pend_in    = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_type_in   = rsp_type_ff;
      rsp_action_in = rsp_action_ff;
      rsp_alg_in    = rsp_alg_ff;
      unique case (state_ff)
         SB_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = SB_IDLE;
            end
         end
         SB_IDLE: begin
            if (pop) begin
               if (head.item.req_type == wftc_pkg::REQ_WRITE) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = wftc_pkg::STATUS_WRITTEN;
                  rsp_type_in   = 8'd0;
                  rsp_action_in = 8'd0;
                  rsp_alg_in    = 8'd0;
               end else begin
                  scan_in  = '0;
                  state_in = SB_SCAN;
               end
            end
         end
         SB_SCAN: begin
            if (hit) begin
               rsp_load      = 1'b1;
               rsp_status_in = wftc_pkg::STATUS_MATCH;
               rsp_type_in   = rd_meta.rule_type;
               rsp_action_in = rd_meta.rule_action;
               rsp_alg_in    = rd_meta.rule_alg;
               state_in      = SB_IDLE;
            end else if (rd_pend_ff && scan_end) begin
               rsp_load      = 1'b1;
               rsp_status_in = wftc_pkg::STATUS_NOMATCH;
               rsp_type_in   = 8'd0;
               rsp_action_in = 8'd0;
               rsp_alg_in    = 8'd0;
               state_in      = SB_IDLE;
            end else if (!scan_end) begin
               scan_in    = scan_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
         end
         default: begin
            state_in = SB_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SB_CLEAR;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      if (pop) begin
         cur_ff <= head.item;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_type_ff   <= rsp_type_in;
         rsp_action_ff <= rsp_action_in;
         rsp_alg_ff    <= rsp_alg_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_policy_type   = rsp_type_ff;
   assign rsp_policy_action = rsp_action_ff;
   assign rsp_policy_alg    = rsp_alg_ff;

endmodule

`default_nettype wire
